[design/prd_pkg.sv]
package prd_pkg;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD1_W   = DIFF_W + DIR_W;
	localparam int DOT_W     = PROD1_W + 2;
	localparam int FRAC_BITS = 16;
	// A rounded ray parameter stays below 3 * 2^33.
	localparam int T_W       = 35;
	localparam int PROD2_W   = T_W + 1 + DIR_W + 1;
	localparam int STEP_W    = PROD2_W - FRAC_BITS;
	localparam int CSUM_W    = STEP_W + 1;
	localparam int SQ_W      = 64;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int RAY_W     = 33;

	localparam int S_DATA_W  = 248;
	localparam int M_DATA_W  = 200;
	localparam int P_OFS     = 0;
	localparam int O_OFS     = 3 * COORD_W;
	localparam int D_OFS     = 6 * COORD_W;

	localparam logic [RAY_W-1:0] T_MAX = '1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIR_W-1:0] dir_t;

	typedef struct packed {
		logic               want_root;
		logic [SQ_W-1:0]    sq;
		logic [RAY_W-1:0]   ray_param;
		coord_t             cx;
		coord_t             cy;
		coord_t             cz;
	} side_t;

endpackage

[design/prd_isqrt.sv]
module prd_isqrt #(
	parameter int STEPS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [prd_pkg::SQ_W-1:0]     in_x,
	input  prd_pkg::side_t               in_side,
	output logic                         out_valid,
	output logic [prd_pkg::ROOT_W-1:0]   out_root,
	output prd_pkg::side_t               out_side
);

	localparam int STAGES = prd_pkg::ROOT_W / STEPS;
	localparam int RW     = prd_pkg::ROOT_W + 3;

	logic                         vld_s  [STAGES];
	logic [RW-1:0]                rem_s  [STAGES];
	logic [prd_pkg::ROOT_W-1:0]   root_s [STAGES];
	logic [prd_pkg::SQ_W-1:0]     x_s    [STAGES];
	prd_pkg::side_t               side_s [STAGES];

	genvar k;
	generate
		for (k = 0; k < STAGES; k++) begin : g_stage
			logic                         vld_in;
			logic [RW-1:0]                rem_in;
			logic [prd_pkg::ROOT_W-1:0]   root_in;
			logic [prd_pkg::SQ_W-1:0]     x_in;
			prd_pkg::side_t               side_in;
			logic [RW-1:0]                rem_nx;
			logic [prd_pkg::ROOT_W-1:0]   root_nx;
			logic [prd_pkg::SQ_W-1:0]     x_nx;
			logic [RW-1:0]                trial;

			if (k == 0) begin : g_first
				assign vld_in  = in_valid;
				assign rem_in  = '0;
				assign root_in = '0;
				assign x_in    = in_x;
				assign side_in = in_side;
			end else begin : g_next
				assign vld_in  = vld_s[k-1];
				assign rem_in  = rem_s[k-1];
				assign root_in = root_s[k-1];
				assign x_in    = x_s[k-1];
				assign side_in = side_s[k-1];
			end

			// Restoring square root, two radicand bits per step.
			always_comb begin
				rem_nx  = rem_in;
				root_nx = root_in;
				x_nx    = x_in;
				trial   = '0;
				for (int j = 0; j < STEPS; j++) begin
					rem_nx = {rem_nx[RW-3:0], x_nx[prd_pkg::SQ_W-1 -: 2]};
					x_nx   = {x_nx[prd_pkg::SQ_W-3:0], 2'b00};
					trial  = {1'b0, root_nx, 2'b01};
					if (rem_nx >= trial) begin
						rem_nx  = rem_nx - trial;
						root_nx = {root_nx[prd_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						root_nx = {root_nx[prd_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= rem_nx;
					root_s[k] <= root_nx;
					x_s[k]    <= x_nx;
					side_s[k] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[STAGES-1];
	assign out_root  = root_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];

endmodule

[design/point_ray_distance_3d.sv]
// Channel   Direction  tdata fields (low bit up)                         tuser
// s_axis    in         point_x, point_y, point_z, ray_origin_x/y/z,       want_root
//                      ray_dir_x, ray_dir_y, ray_dir_z, zero fill
// m_axis    out        dist_value, ray_param, closest_x/y/z, zero fill   none
//
// One word is taken per cycle while the output is not stalled.
// Seven arithmetic stages are followed by the square root pipeline, whose
// SQRT_STEPS root bits per stage set its depth.
// The whole pipeline advances together: a stalled output word freezes every stage.
// Reset clears only the valid bits.
module point_ray_distance_3d #(
	parameter int SQRT_STEPS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// point_x, point_y, point_z, ray_origin_x, ray_origin_y, ray_origin_z,
	// ray_dir_x, ray_dir_y, ray_dir_z, zero fill
	input  logic [prd_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// want_root
	input  logic [0:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// dist_value, ray_param, closest_x, closest_y, closest_z, zero fill
	output logic [prd_pkg::M_DATA_W-1:0]    m_axis_tdata
);

	logic en;

	prd_pkg::coord_t p_in [3];
	prd_pkg::coord_t o_in [3];
	prd_pkg::dir_t   d_in [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_in[i] = s_axis_tdata[prd_pkg::P_OFS + i*prd_pkg::COORD_W +: prd_pkg::COORD_W];
			o_in[i] = s_axis_tdata[prd_pkg::O_OFS + i*prd_pkg::COORD_W +: prd_pkg::COORD_W];
			d_in[i] = s_axis_tdata[prd_pkg::D_OFS + i*prd_pkg::DIR_W +: prd_pkg::DIR_W];
		end
	end

	// Stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic root_s1, root_s2, root_s3, root_s4, root_s5, root_s6, root_s7;

	prd_pkg::coord_t p_s1 [3], p_s2 [3], p_s3 [3], p_s4 [3], p_s5 [3];
	prd_pkg::coord_t o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3];
	prd_pkg::dir_t   d_s1 [3], d_s2 [3], d_s3 [3];
	prd_pkg::coord_t c_s5 [3], c_s6 [3], c_s7 [3];

	logic signed [prd_pkg::PROD1_W-1:0] prod_s1 [3];
	logic signed [prd_pkg::DOT_W-1:0]   dot_s2;
	logic [prd_pkg::T_W-1:0]            t_s3;
	logic [prd_pkg::RAY_W-1:0]          ray_s3, ray_s4, ray_s5, ray_s6, ray_s7;
	logic signed [prd_pkg::PROD2_W-1:0] prod_s4 [3];
	logic [prd_pkg::SQ_W-1:0]           sqp_s6 [3];
	logic [prd_pkg::SQ_W-1:0]           sq_s7;

	// Combinational results of each stage
	logic signed [prd_pkg::DIFF_W-1:0]  diff1 [3];
	logic signed [prd_pkg::PROD1_W-1:0] prod1 [3];
	logic signed [prd_pkg::DOT_W-1:0]   dot2;
	logic signed [prd_pkg::DOT_W-1:0]   dot_rnd;
	logic [prd_pkg::T_W-1:0]            t3;
	logic [prd_pkg::RAY_W-1:0]          ray3;
	logic signed [prd_pkg::PROD2_W-1:0] prod4 [3];
	logic signed [prd_pkg::PROD2_W-1:0] step_rnd [3];
	logic signed [prd_pkg::STEP_W-1:0]  step5 [3];
	logic signed [prd_pkg::CSUM_W-1:0]  csum5 [3];
	prd_pkg::coord_t                    c5 [3];
	logic signed [prd_pkg::DIFF_W-1:0]  diff6 [3];
	logic [prd_pkg::DIFF_W-1:0]         neg6 [3];
	logic [prd_pkg::COORD_W-1:0]        mag6 [3];
	logic [prd_pkg::SQ_W-1:0]           sqp6 [3];
	logic [prd_pkg::SQ_W+1:0]           sum7;
	logic [prd_pkg::SQ_W-1:0]           sq7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff1[i] = prd_pkg::DIFF_W'(p_in[i]) - prd_pkg::DIFF_W'(o_in[i]);
			prod1[i] = prd_pkg::PROD1_W'(diff1[i]) * prd_pkg::PROD1_W'(d_in[i]);
		end

		dot2 = prd_pkg::DOT_W'(prod_s1[0]) + prd_pkg::DOT_W'(prod_s1[1])
			+ prd_pkg::DOT_W'(prod_s1[2]);

		// A non-positive dot product clamps the ray parameter to zero.
		dot_rnd = dot_s2 + prd_pkg::DOT_W'(1 << (prd_pkg::FRAC_BITS - 1));
		t3 = (!dot_s2[prd_pkg::DOT_W-1] && dot_s2 != '0)
			? dot_rnd[prd_pkg::FRAC_BITS +: prd_pkg::T_W] : '0;
		ray3 = (t3[prd_pkg::T_W-1:prd_pkg::RAY_W] != '0) ? prd_pkg::T_MAX
			: t3[prd_pkg::RAY_W-1:0];

		for (int i = 0; i < 3; i++) begin
			prod4[i] = prd_pkg::PROD2_W'($signed({1'b0, t_s3})) * prd_pkg::PROD2_W'(d_s3[i]);

			step_rnd[i] = prod_s4[i] + prd_pkg::PROD2_W'(1 << (prd_pkg::FRAC_BITS - 1));
			step5[i] = step_rnd[i][prd_pkg::PROD2_W-1:prd_pkg::FRAC_BITS];
			csum5[i] = prd_pkg::CSUM_W'(o_s4[i]) + prd_pkg::CSUM_W'(step5[i]);
			// Saturate when the sign bit of a 32-bit word and the bits above it disagree.
			if (csum5[i][prd_pkg::CSUM_W-1:prd_pkg::COORD_W-1] == '0
				|| csum5[i][prd_pkg::CSUM_W-1:prd_pkg::COORD_W-1] == '1) begin
				c5[i] = csum5[i][prd_pkg::COORD_W-1:0];
			end else if (csum5[i][prd_pkg::CSUM_W-1]) begin
				c5[i] = {1'b1, {(prd_pkg::COORD_W-1){1'b0}}};
			end else begin
				c5[i] = {1'b0, {(prd_pkg::COORD_W-1){1'b1}}};
			end

			diff6[i] = prd_pkg::DIFF_W'(c_s5[i]) - prd_pkg::DIFF_W'(p_s5[i]);
			neg6[i]  = -diff6[i];
			mag6[i]  = diff6[i][prd_pkg::DIFF_W-1] ? neg6[i][prd_pkg::COORD_W-1:0]
				: diff6[i][prd_pkg::COORD_W-1:0];
			sqp6[i]  = prd_pkg::SQ_W'(mag6[i]) * prd_pkg::SQ_W'(mag6[i]);
		end

		sum7 = (prd_pkg::SQ_W+2)'(sqp_s6[0]) + (prd_pkg::SQ_W+2)'(sqp_s6[1])
			+ (prd_pkg::SQ_W+2)'(sqp_s6[2]);
		sq7 = (sum7[prd_pkg::SQ_W+1:prd_pkg::SQ_W] != '0) ? '1 : sum7[prd_pkg::SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s1 <= s_axis_tuser[0];
			root_s2 <= root_s1;
			root_s3 <= root_s2;
			root_s4 <= root_s3;
			root_s5 <= root_s4;
			root_s6 <= root_s5;
			root_s7 <= root_s6;

			for (int i = 0; i < 3; i++) begin
				p_s1[i]    <= p_in[i];
				o_s1[i]    <= o_in[i];
				d_s1[i]    <= d_in[i];
				prod_s1[i] <= prod1[i];

				p_s2[i] <= p_s1[i];
				o_s2[i] <= o_s1[i];
				d_s2[i] <= d_s1[i];

				p_s3[i] <= p_s2[i];
				o_s3[i] <= o_s2[i];
				d_s3[i] <= d_s2[i];

				p_s4[i]    <= p_s3[i];
				o_s4[i]    <= o_s3[i];
				prod_s4[i] <= prod4[i];

				p_s5[i] <= p_s4[i];
				c_s5[i] <= c5[i];

				c_s6[i]   <= c_s5[i];
				sqp_s6[i] <= sqp6[i];

				c_s7[i] <= c_s6[i];
			end

			dot_s2 <= dot2;
			t_s3   <= t3;
			ray_s3 <= ray3;
			ray_s4 <= ray_s3;
			ray_s5 <= ray_s4;
			ray_s6 <= ray_s5;
			ray_s7 <= ray_s6;
			sq_s7  <= sq7;
		end
	end

	prd_pkg::side_t               side7;
	prd_pkg::side_t               side_out;
	logic [prd_pkg::ROOT_W-1:0]   root_out;
	logic [prd_pkg::SQ_W-1:0]     dist_value;

	assign side7.want_root = root_s7;
	assign side7.sq        = sq_s7;
	assign side7.ray_param = ray_s7;
	assign side7.cx        = c_s7[0];
	assign side7.cy        = c_s7[1];
	assign side7.cz        = c_s7[2];

	prd_isqrt #(
		.STEPS (SQRT_STEPS)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.in_x      (sq_s7),
		.in_side   (side7),
		.out_valid (m_axis_tvalid),
		.out_root  (root_out),
		.out_side  (side_out)
	);

	// The last square root stage is the output register.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	assign dist_value = side_out.want_root ? prd_pkg::SQ_W'(root_out) : side_out.sq;

	assign m_axis_tdata = {
		{(prd_pkg::M_DATA_W - prd_pkg::SQ_W - prd_pkg::RAY_W - 3*prd_pkg::COORD_W){1'b0}},
		side_out.cz, side_out.cy, side_out.cx, side_out.ray_param, dist_value
	};

endmodule

[design/prd_chk.sv]
module prd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [prd_pkg::M_DATA_W-1:0]  m_axis_tdata
);

	// An output word waiting on the sink keeps presenting itself.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// The pipeline moves exactly when the output register is free or drained.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stall");

	// A stall holds off new input words.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted during an output stall");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind point_ray_distance_3d prd_chk u_prd_chk (.*);

[sim/tb_point_ray_distance_3d.sv]
`timescale 1ns / 100ps

module tb_point_ray_distance_3d;

	typedef struct packed {
		prd_pkg::coord_t     px;
		prd_pkg::coord_t     py;
		prd_pkg::coord_t     pz;
		prd_pkg::coord_t     ox;
		prd_pkg::coord_t     oy;
		prd_pkg::coord_t     oz;
		prd_pkg::dir_t       dx;
		prd_pkg::dir_t       dy;
		prd_pkg::dir_t       dz;
		logic                root;
	} query_t;

	typedef struct packed {
		logic [prd_pkg::SQ_W-1:0]  dist_val;
		logic [prd_pkg::RAY_W-1:0] ray;
		prd_pkg::coord_t           cx;
		prd_pkg::coord_t           cy;
		prd_pkg::coord_t           cz;
	} result_t;

	typedef struct packed {
		query_t  q;
		logic    fixed;
		result_t res;
	} row_t;

	localparam prd_pkg::coord_t CMAX   = 32'sh7FFF_FFFF;
	localparam prd_pkg::coord_t CMIN   = 32'sh8000_0000;
	localparam prd_pkg::coord_t ONE    = 32'sh0001_0000;
	localparam prd_pkg::dir_t   D_ONE  = 18'sh10000;
	localparam prd_pkg::dir_t   D_NEG  = 18'sh30000;
	localparam prd_pkg::dir_t   D_HALF = 18'sh08000;

	localparam int N_DIRECTED  = 16;
	localparam int N_RANDOM    = 1934;
	localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_AT    = 1200;
	localparam int STALL_LIMIT = 3000;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [prd_pkg::S_DATA_W-1:0]   s_axis_tdata;
	logic [0:0]                     s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [prd_pkg::M_DATA_W-1:0]   m_axis_tdata;

	result_t pending_distances[$];
	row_t    directed_rows[N_DIRECTED];
	int      errors;
	int      stall_count;
	bit      calm;
	bit      hold_req;

	point_ray_distance_3d DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] floor_root(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] cand;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (32'd1 << b);
			if (64'(cand) * 64'(cand) <= v)
				r = cand;
		end
		return r;
	endfunction

	function automatic result_t predict_distance(input query_t q);
		longint      pt[3];
		longint      org[3];
		longint      dv[3];
		longint      cp[3];
		longint      dot;
		longint      t;
		longint      diff;
		logic [63:0] mag;
		logic [64:0] acc;
		result_t     r;
		pt  = '{longint'($signed(q.px)), longint'($signed(q.py)), longint'($signed(q.pz))};
		org = '{longint'($signed(q.ox)), longint'($signed(q.oy)), longint'($signed(q.oz))};
		dv  = '{longint'($signed(q.dx)), longint'($signed(q.dy)), longint'($signed(q.dz))};
		dot = 0;
		for (int i = 0; i < 3; i++)
			dot += dv[i] * (pt[i] - org[i]);
		// Round half up to Q.16; a non-positive projection pins C to the origin.
		t = (dot > 0) ? ((dot + 64'sd32768) >>> prd_pkg::FRAC_BITS) : 64'sd0;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			cp[i] = org[i] + ((t * dv[i] + 64'sd32768) >>> prd_pkg::FRAC_BITS);
			if (cp[i] > longint'(CMAX))
				cp[i] = longint'(CMAX);
			else if (cp[i] < longint'(CMIN))
				cp[i] = longint'(CMIN);
			diff = cp[i] - pt[i];
			mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
			acc  = acc + 65'(mag) * 65'(mag);
			if (acc[64])
				acc = {1'b0, {64{1'b1}}};
		end
		r.dist_val = q.root ? 64'(floor_root(acc[63:0])) : acc[63:0];
		r.ray      = (t > longint'(prd_pkg::T_MAX)) ? prd_pkg::T_MAX : t[prd_pkg::RAY_W-1:0];
		r.cx       = prd_pkg::coord_t'(cp[0]);
		r.cy       = prd_pkg::coord_t'(cp[1]);
		r.cz       = prd_pkg::coord_t'(cp[2]);
		return r;
	endfunction

	function automatic prd_pkg::coord_t rand_coord();
		prd_pkg::coord_t v;
		case ($urandom_range(0, 7))
			0, 1: v = prd_pkg::coord_t'($urandom);
			2: begin
				case ($urandom_range(0, 4))
					0: v = CMAX;
					1: v = CMIN;
					2: v = '0;
					3: v = ONE;
					default: v = -32'sd1;
				endcase
			end
			default: v = prd_pkg::coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
		endcase
		return v;
	endfunction

	function automatic prd_pkg::dir_t rand_dir();
		prd_pkg::dir_t v;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: v = D_ONE;
					1: v = D_NEG;
					2: v = D_HALF;
					default: v = '0;
				endcase
			end
			default: v = prd_pkg::dir_t'(int'($urandom_range(0, 131072)) - 65536);
		endcase
		return v;
	endfunction

	function automatic query_t rand_query();
		query_t q;
		q.px = rand_coord();
		q.py = rand_coord();
		q.pz = rand_coord();
		// Half of the queries put the origin near the point, so that the
		// projection and distance stay in a range where rounding shows.
		if ($urandom_range(0, 1)) begin
			q.ox = q.px + prd_pkg::coord_t'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
			q.oy = q.py + prd_pkg::coord_t'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
			q.oz = q.pz + prd_pkg::coord_t'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
		end else begin
			q.ox = rand_coord();
			q.oy = rand_coord();
			q.oz = rand_coord();
		end
		q.dx   = rand_dir();
		q.dy   = rand_dir();
		q.dz   = rand_dir();
		q.root = 1'($urandom_range(0, 1));
		return q;
	endfunction

	// Sender: directed rows first, then random queries.
	initial begin
		query_t q;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		errors        = 0;

		directed_rows[0]  = '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			18'sd0, 18'sd0, 18'sd0, 1'b0}, 1'b1, '{64'd0, 33'd0, 32'sd0, 32'sd0, 32'sd0}};
		directed_rows[1]  = '{'{ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			D_ONE, 18'sd0, 18'sd0, 1'b0}, 1'b1, '{64'd0, 33'h10000, ONE, 32'sd0, 32'sd0}};
		// Point behind the origin: t clamps to zero.
		directed_rows[2]  = '{'{-ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			D_ONE, 18'sd0, 18'sd0, 1'b0}, 1'b1,
			'{64'h1_0000_0000, 33'd0, 32'sd0, 32'sd0, 32'sd0}};
		directed_rows[3]  = '{'{-ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			D_ONE, 18'sd0, 18'sd0, 1'b1}, 1'b1,
			'{64'h1_0000, 33'd0, 32'sd0, 32'sd0, 32'sd0}};
		// Huge t: ray_param and all closest coordinates saturate high.
		directed_rows[4]  = '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
			D_ONE, D_ONE, D_ONE, 1'b0}, 1'b1, '{64'd0, prd_pkg::T_MAX, CMAX, CMAX, CMAX}};
		directed_rows[5]  = '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
			D_ONE, D_ONE, D_ONE, 1'b1}, 1'b1, '{64'd0, prd_pkg::T_MAX, CMAX, CMAX, CMAX}};
		// Largest separation: the squared distance saturates to all ones.
		directed_rows[6]  = '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
			D_ONE, D_ONE, D_ONE, 1'b0}, 1'b1, '{{64{1'b1}}, 33'd0, CMAX, CMAX, CMAX}};
		directed_rows[7]  = '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
			D_ONE, D_ONE, D_ONE, 1'b1}, 1'b1,
			'{64'hFFFF_FFFF, 33'd0, CMAX, CMAX, CMAX}};
		directed_rows[8]  = '{'{CMAX, CMIN, 32'sd0, CMIN, CMAX, ONE,
			D_NEG, D_NEG, D_NEG, 1'b0}, 1'b0, '0};
		// Zero direction.
		directed_rows[9]  = '{'{32'sd196608, -32'sd327680, 32'sd7, -ONE, ONE, 32'sd0,
			18'sd0, 18'sd0, 18'sd0, 1'b1}, 1'b0, '0};
		// A dot product of exactly half an LSB rounds up to t = 1.
		directed_rows[10] = '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			D_HALF, 18'sd0, 18'sd0, 1'b0}, 1'b0, '0};
		// A positive dot product below half an LSB rounds to t = 0.
		directed_rows[11] = '{'{32'sd32767, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			18'sd1, 18'sd0, 18'sd0, 1'b0}, 1'b0, '0};
		// A negative half product rounds toward plus infinity.
		directed_rows[12] = '{'{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			D_HALF, -D_HALF, 18'sd0, 1'b1}, 1'b0, '0};
		// Closest point saturates low.
		directed_rows[13] = '{'{CMIN, CMIN, CMIN, 32'sd0, CMIN, CMIN,
			D_NEG, D_NEG, D_NEG, 1'b0}, 1'b0, '0};
		// Direction not of unit length.
		directed_rows[14] = '{'{32'sd6553600, -32'sd3276800, 32'sd1310720, ONE, ONE, ONE,
			D_ONE, D_ONE, D_NEG, 1'b1}, 1'b0, '0};
		directed_rows[15] = '{'{CMAX, CMAX, CMIN, CMIN, CMIN, CMAX,
			D_ONE, D_ONE, D_NEG, 1'b1}, 1'b0, '0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_TOTAL; n++) begin
			q = (n < N_DIRECTED) ? directed_rows[n].q : rand_query();
			calm = (n >= N_TOTAL - 250) || ((n / 150) % 3 == 1);
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == DRAIN_AT) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_distances.size() != 0);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {2'b00, q.dz, q.dy, q.dx, q.oz, q.oy, q.ox, q.pz, q.py, q.px};
			s_axis_tuser  <= q.root;
			do @(posedge clk); while (!s_axis_tready);
			if (n < N_DIRECTED && directed_rows[n].fixed)
				pending_distances.push_back(directed_rows[n].res);
			else
				pending_distances.push_back(predict_distance(q));
			if (!calm && $urandom_range(0, 3) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_distances.size() != 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Receiver: random back-pressure plus one long hold-off.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_distances.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_distances.pop_front();
				if (m_axis_tdata[63:0] !== want.dist_val)
					report_field("dist_value", want.dist_val, m_axis_tdata[63:0]);
				if (m_axis_tdata[96:64] !== want.ray)
					report_field("ray_param", 64'(want.ray), 64'(m_axis_tdata[96:64]));
				if (m_axis_tdata[128:97] !== want.cx)
					report_field("closest_x", 64'(want.cx), 64'(m_axis_tdata[128:97]));
				if (m_axis_tdata[160:129] !== want.cy)
					report_field("closest_y", 64'(want.cy), 64'(m_axis_tdata[160:129]));
				if (m_axis_tdata[192:161] !== want.cz)
					report_field("closest_z", 64'(want.cz), 64'(m_axis_tdata[192:161]));
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_count <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

endmodule
